[src/ssn_pkg.sv]
// ----------------------------------------------------------------------------
// Sparse spiking neuron step package
// Shared types, constants and opcodes for the neuron step block.
// ----------------------------------------------------------------------------
package ssn_pkg;

    localparam int unsigned MAX_NEURONS_DEF  = 1024;
    localparam int unsigned NUM_SOURCES_DEF  = 1024;
    localparam int unsigned MAX_SYNAPSES_DEF = 16384;

    localparam int unsigned WEIGHT_SHIFT  = 10;
    localparam int unsigned CURRENT_SHIFT = 6;
    localparam int unsigned LEAK_SHIFT    = 14;

    localparam logic [15:0] LEAK_RESET  = 16'd14746;
    localparam logic [10:0] COUNT_RESET = 11'd1024;

    localparam logic [1:0] REG_LEAK    = 2'd0;
    localparam logic [1:0] REG_NEURONS = 2'd1;
    localparam logic [1:0] REG_SOURCES = 2'd2;

    typedef enum logic [2:0] {
        OP_ROW_PTR = 3'd0,
        OP_SYNAPSE = 3'd1,
        OP_NEURON  = 3'd2,
        OP_SPIKE   = 3'd3,
        OP_UPDATE  = 3'd4
    } t_opcode;

    typedef struct packed {
        logic [2:0]         opcode;
        logic [10:0]        source_index;
        logic [9:0]         neuron_index;
        logic [14:0]        synapse_pos;
        logic signed [7:0]  weight;
        logic signed [15:0] potential;
        logic signed [15:0] threshold;
        logic               refractory_in;
        logic               spiked_in;
    } t_item;

    typedef struct packed {
        logic               fired;
        logic signed [15:0] new_potential;
        logic               skipped;
    } t_result;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PTR,
        ST_WALK,
        ST_UPD_RD,
        ST_UPD_MUL,
        ST_UPD_OUT
    } t_state;

endpackage

[src/ssn_if.sv]
// ----------------------------------------------------------------------------
// Sparse spiking neuron stream interfaces
// Valid/ready channels for input items and results.
// ----------------------------------------------------------------------------
interface ssn_item_if;
    logic               valid;
    logic               ready;
    ssn_pkg::t_item     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ssn_result_if;
    logic               valid;
    logic               ready;
    ssn_pkg::t_result   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[src/ssn_front.sv]
// ----------------------------------------------------------------------------
// Sparse spiking neuron front end
// Accepts items, drops ones that do nothing, and queues the rest.
// ----------------------------------------------------------------------------
module ssn_front #(
    parameter int unsigned MAX_NEURONS  = ssn_pkg::MAX_NEURONS_DEF,
    parameter int unsigned NUM_SOURCES  = ssn_pkg::NUM_SOURCES_DEF,
    parameter int unsigned MAX_SYNAPSES = ssn_pkg::MAX_SYNAPSES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [10:0]      i_neuron_count,
    input  logic [10:0]      i_source_count,
    ssn_item_if.sink         s_in,
    output logic             o_q_valid,
    output ssn_pkg::t_item   o_q_item,
    input  logic             i_q_pop
);
    import ssn_pkg::*;

    localparam int unsigned DEPTH = 4;

    t_item      r_mem [DEPTH];
    logic [1:0] r_wr, r_rd;
    logic [2:0] r_cnt;
    logic       keep;
    logic       push;
    logic       pop;

    always_comb begin
        keep = 1'b0;
        case (s_in.data.opcode)
            OP_ROW_PTR: keep = 32'(s_in.data.source_index) <= NUM_SOURCES;
            OP_SYNAPSE: keep = 32'(s_in.data.synapse_pos) < MAX_SYNAPSES;
            OP_NEURON:  keep = 32'(s_in.data.neuron_index) < MAX_NEURONS;
            OP_SPIKE:   keep = (s_in.data.source_index < i_source_count) &&
                               (32'(s_in.data.source_index) < NUM_SOURCES);
            OP_UPDATE:  keep = ({1'b0, s_in.data.neuron_index} < i_neuron_count) &&
                               (32'(s_in.data.neuron_index) < MAX_NEURONS);
            default:    keep = 1'b0;
        endcase
    end

    assign s_in.ready = r_cnt != 3'(DEPTH);
    assign push       = s_in.valid && s_in.ready && keep;
    assign pop        = i_q_pop && (r_cnt != 3'd0);
    assign o_q_valid  = r_cnt != 3'd0;
    assign o_q_item   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= s_in.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wr <= r_wr + 2'd1;
            if (pop)  r_rd <= r_rd + 2'd1;
            r_cnt <= r_cnt + 3'(push) - 3'(pop);
        end
    end

endmodule

[src/ssn_back.sv]
// ----------------------------------------------------------------------------
// Sparse spiking neuron back end
// Holds the tables and carries out loads, spike walks and neuron updates.
// ----------------------------------------------------------------------------
module ssn_back #(
    parameter int unsigned MAX_NEURONS  = ssn_pkg::MAX_NEURONS_DEF,
    parameter int unsigned NUM_SOURCES  = ssn_pkg::NUM_SOURCES_DEF,
    parameter int unsigned MAX_SYNAPSES = ssn_pkg::MAX_SYNAPSES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [15:0]      i_leak,
    input  logic             i_q_valid,
    input  ssn_pkg::t_item   i_q_item,
    output logic             o_q_pop,
    ssn_result_if.source     m_out
);
    import ssn_pkg::*;

    localparam int unsigned NW = (MAX_NEURONS > 1) ? $clog2(MAX_NEURONS) : 1;
    localparam int unsigned SW = (MAX_SYNAPSES > 1) ? $clog2(MAX_SYNAPSES) : 1;
    localparam int unsigned RW = $clog2(NUM_SOURCES + 1);
    localparam int unsigned PW = $clog2(MAX_SYNAPSES + 1) > 15 ?
                                 $clog2(MAX_SYNAPSES + 1) : 15;

    // Row pointers, synapses and neuron records; currents are zeroed by a
    // clearing pass after reset.
    logic [14:0]        r_rowp   [NUM_SOURCES + 1];
    logic [9:0]         r_starg  [MAX_SYNAPSES];
    logic [7:0]         r_swgt   [MAX_SYNAPSES];
    logic [15:0]        r_npot   [MAX_NEURONS];
    logic [15:0]        r_nthr   [MAX_NEURONS];
    logic               r_nref   [MAX_NEURONS];
    logic               r_nspk   [MAX_NEURONS];
    logic [31:0]        r_cur    [MAX_NEURONS];

    t_state r_state, n_state;
    t_item  r_it;
    logic [NW-1:0] r_clr_idx;
    logic [14:0] r_ptr_b;
    logic [PW-1:0] r_idx;
    logic [9:0]  r_tg;
    logic [7:0]  r_wt;
    logic        r_acc_vld;
    logic [31:0] r_cur_rd;
    logic [NW-1:0] r_add_n;
    logic [7:0]  r_add_w;
    logic        r_add_vld;
    logic [NW-1:0] r_last_n;
    logic [31:0] r_last_val;
    logic        r_last_vld;
    logic [15:0] r_v, r_th;
    logic        r_ref;
    logic [31:0] r_c;
    logic signed [32:0] r_prod;
    logic        r_out_vld;
    t_result     r_out;

    logic        take;
    logic [PW-1:0] walk_end;
    logic        walk_more;
    logic [NW-1:0] un;
    logic [NW-1:0] acc_n;
    logic        acc_in_range;
    logic [31:0] acc_base;
    logic [31:0] acc_sum;
    logic        upd_done;
    logic        upd_wr;
    logic signed [33:0] vsum;
    logic signed [16:0] vsat;
    logic signed [16:0] vdiff;
    logic        fire;
    logic [15:0] vnew;

    assign take    = (r_state == ST_IDLE) && i_q_valid;
    assign o_q_pop = take;
    assign un      = NW'(r_it.neuron_index);

    // Clamp the row end at the table size.
    assign walk_end  = (32'(r_ptr_b) > MAX_SYNAPSES) ? PW'(MAX_SYNAPSES) : PW'(r_ptr_b);
    assign walk_more = r_idx < walk_end;

    assign upd_done = (r_state == ST_UPD_OUT) && (n_state == ST_IDLE);
    assign upd_wr   = upd_done && !r_ref;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR:   if (r_clr_idx == NW'(MAX_NEURONS - 1)) n_state = ST_IDLE;
            ST_IDLE: begin
                if (i_q_valid) begin
                    if (i_q_item.opcode == OP_SPIKE)       n_state = ST_PTR;
                    else if (i_q_item.opcode == OP_UPDATE) n_state = ST_UPD_RD;
                end
            end
            ST_PTR:     n_state = ST_WALK;
            ST_WALK:    if (!walk_more) n_state = ST_IDLE;
            ST_UPD_RD:  n_state = ST_UPD_MUL;
            ST_UPD_MUL: n_state = ST_UPD_OUT;
            ST_UPD_OUT: if (!r_out_vld || m_out.ready) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // Accumulate pipeline: synapse read, current read, add and write back.
    // A write at the same edge as the current read is forwarded.
    assign acc_n        = NW'(r_tg);
    assign acc_in_range = 32'(r_tg) < MAX_NEURONS;
    assign acc_base     = (r_last_vld && r_last_n == r_add_n) ? r_last_val : r_cur_rd;
    assign acc_sum      = acc_base + (32'($signed(r_add_w)) << WEIGHT_SHIFT);

    // Update arithmetic.
    assign vsum  = 34'(r_prod >>> LEAK_SHIFT) +
                   34'($signed(r_c) >>> CURRENT_SHIFT);
    assign vsat  = (vsum > 34'sd32767) ? 17'sd32767 :
                   (vsum < -34'sd32768) ? -17'sd32768 : 17'(vsum);
    assign fire  = vsat >= 17'($signed(r_th));
    assign vdiff = vsat - 17'($signed(r_th));
    assign vnew  = fire ? vdiff[15:0] : vsat[15:0];

    always_ff @(posedge i_clk) begin
        if (r_state == ST_CLEAR) r_cur[r_clr_idx] <= '0;
        else if (r_add_vld) r_cur[r_add_n] <= acc_sum;
        else if (upd_wr) r_cur[un] <= '0;
    end

    always_ff @(posedge i_clk) begin
        if (take) r_it <= i_q_item;
        if (take) begin
            case (i_q_item.opcode)
                OP_ROW_PTR: r_rowp[RW'(i_q_item.source_index)] <= i_q_item.synapse_pos;
                OP_SYNAPSE: begin
                    r_starg[SW'(i_q_item.synapse_pos)] <= i_q_item.neuron_index;
                    r_swgt[SW'(i_q_item.synapse_pos)]  <= i_q_item.weight;
                end
                OP_NEURON: begin
                    r_npot[NW'(i_q_item.neuron_index)] <= i_q_item.potential;
                    r_nthr[NW'(i_q_item.neuron_index)] <= i_q_item.threshold;
                    r_nref[NW'(i_q_item.neuron_index)] <= i_q_item.refractory_in;
                    r_nspk[NW'(i_q_item.neuron_index)] <= i_q_item.spiked_in;
                end
                default: ;
            endcase
        end
        if (r_state == ST_PTR) begin
            r_idx   <= PW'(r_rowp[RW'(r_it.source_index)]);
            r_ptr_b <= r_rowp[RW'(12'(r_it.source_index) + 12'd1)];
        end else if (r_state == ST_WALK && walk_more) begin
            r_idx <= r_idx + PW'(1);
        end
        if (r_state == ST_WALK && walk_more) begin
            r_tg <= r_starg[SW'(r_idx)];
            r_wt <= r_swgt[SW'(r_idx)];
        end
        if (r_acc_vld && acc_in_range) begin
            r_cur_rd <= r_cur[acc_n];
            r_add_n  <= acc_n;
            r_add_w  <= r_wt;
        end
        if (r_add_vld) begin
            r_last_n   <= r_add_n;
            r_last_val <= acc_sum;
        end
        if (r_state == ST_UPD_RD) begin
            r_v   <= r_npot[un];
            r_th  <= r_nthr[un];
            r_ref <= r_nref[un];
            r_c   <= r_cur[un];
        end
        if (r_state == ST_UPD_MUL) begin
            r_prod <= $signed({1'b0, i_leak}) * $signed(r_v);
        end
        if (upd_done) begin
            if (r_ref) begin
                r_out <= '{fired: 1'b0, new_potential: r_v, skipped: 1'b1};
            end else begin
                r_out <= '{fired: fire, new_potential: vnew, skipped: 1'b0};
                r_npot[un] <= vnew;
                r_nspk[un] <= fire;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_idx  <= '0;
            r_acc_vld  <= 1'b0;
            r_add_vld  <= 1'b0;
            r_last_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            if (r_state == ST_CLEAR) r_clr_idx <= r_clr_idx + NW'(1);
            r_acc_vld  <= (r_state == ST_WALK) && walk_more;
            r_add_vld  <= r_acc_vld && acc_in_range;
            r_last_vld <= r_add_vld;
            if (upd_done) r_out_vld <= 1'b1;
            else if (m_out.ready) r_out_vld <= 1'b0;
        end
    end

    assign m_out.valid = r_out_vld;
    assign m_out.data  = r_out;

endmodule

[src/sparse_spiking_neuron_step.sv]
// ----------------------------------------------------------------------------
// Sparse spiking neuron step
// Leaky integrate-and-fire neurons fed through sparse row synapse tables.
// ----------------------------------------------------------------------------
// Items arrive on s_in and pass a four-entry queue; loads, spikes and updates
// of neurons in range reach the back end, the rest are dropped at once.
// Loads are written to their tables as the back end takes them. A spike reads
// its row pointers, then walks its row one synapse per cycle, a rate set by
// the single read port of the synapse table. An update passes four steps
// (issue, read, multiply, result) and its result is registered for m_out.
// The result waits in an output register; the back end stalls only when a
// second result is ready before the first transfer completes.
// Reset clears the queue and the state machine and sets the registers to
// their defaults. After reset the back end writes zero to every current, one
// neuron per cycle (1024 neurons by default), before it takes an item; the
// queue still accepts up to four items meanwhile. Other tables hold garbage
// until written.
// Registers over APB: 0 leak factor, 1 neuron count, 2 source count.
// ----------------------------------------------------------------------------
module sparse_spiking_neuron_step #(
    parameter int unsigned MAX_NEURONS  = ssn_pkg::MAX_NEURONS_DEF,
    parameter int unsigned NUM_SOURCES  = ssn_pkg::NUM_SOURCES_DEF,
    parameter int unsigned MAX_SYNAPSES = ssn_pkg::MAX_SYNAPSES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    ssn_item_if.sink     s_in,
    ssn_result_if.source m_out
);
    import ssn_pkg::*;

    logic [15:0] r_leak;
    logic [10:0] r_ncnt, r_scnt;
    logic        q_valid, q_pop;
    t_item       q_item;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_leak <= LEAK_RESET;
            r_ncnt <= COUNT_RESET;
            r_scnt <= COUNT_RESET;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_LEAK:    r_leak <= pwdata[15:0];
                REG_NEURONS: r_ncnt <= pwdata[10:0];
                REG_SOURCES: r_scnt <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_LEAK:    prdata = {16'd0, r_leak};
            REG_NEURONS: prdata = {21'd0, r_ncnt};
            REG_SOURCES: prdata = {21'd0, r_scnt};
            default:     prdata = 32'd0;
        endcase
    end

    ssn_front #(
        .MAX_NEURONS(MAX_NEURONS), .NUM_SOURCES(NUM_SOURCES),
        .MAX_SYNAPSES(MAX_SYNAPSES)
    ) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_neuron_count(r_ncnt), .i_source_count(r_scnt),
        .s_in(s_in), .o_q_valid(q_valid), .o_q_item(q_item), .i_q_pop(q_pop)
    );

    ssn_back #(
        .MAX_NEURONS(MAX_NEURONS), .NUM_SOURCES(NUM_SOURCES),
        .MAX_SYNAPSES(MAX_SYNAPSES)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_leak(r_leak),
        .i_q_valid(q_valid), .i_q_item(q_item), .o_q_pop(q_pop), .m_out(m_out)
    );

endmodule

[test/ssn_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sparse spiking neuron step checker
// Watches the item, result and register ports, predicts every update result
// from its own copy of the tables and compares each result field by field.
// ----------------------------------------------------------------------------
module ssn_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    input  logic         pready,
    ssn_item_if          items,
    ssn_result_if        results,
    output int           o_fail_count,
    output int           o_pending,
    output int           o_result_count
);
    import ssn_pkg::*;

    localparam int unsigned SRC_N = NUM_SOURCES_DEF;
    localparam int unsigned NRN_N = MAX_NEURONS_DEF;
    localparam int unsigned SYN_N = MAX_SYNAPSES_DEF;

    logic [15:0] leak;
    logic [10:0] neuron_limit;
    logic [10:0] source_limit;

    logic [14:0] row_ptr [0:SRC_N];
    logic [9:0]  syn_target [0:SYN_N-1];
    logic [7:0]  syn_weight [0:SYN_N-1];
    logic [15:0] nrn_potential [0:NRN_N-1];
    logic [15:0] nrn_threshold [0:NRN_N-1];
    logic        nrn_refractory [0:NRN_N-1];
    logic        nrn_spiked [0:NRN_N-1];
    logic [31:0] nrn_current [0:NRN_N-1];

    t_result update_results_q [$];

    assign o_pending = update_results_q.size();

    task automatic walk_row(input logic [10:0] src);
        int unsigned first_syn;
        int unsigned last_syn;
        logic signed [31:0] w;
        if (src >= source_limit || src >= SRC_N) return;
        first_syn = row_ptr[src];
        last_syn  = row_ptr[src + 1];
        if (last_syn > SYN_N) last_syn = SYN_N;
        for (int unsigned k = first_syn; k < last_syn; k++) begin
            w = 32'(signed'(syn_weight[k]));
            nrn_current[syn_target[k]] += 32'(w <<< WEIGHT_SHIFT);
        end
    endtask

    task automatic lif_update(input logic [9:0] n);
        t_result r;
        longint v;
        longint th;
        longint vn;
        if (n >= neuron_limit) return;
        if (nrn_refractory[n]) begin
            r.fired = 1'b0;
            r.new_potential = nrn_potential[n];
            r.skipped = 1'b1;
        end else begin
            v  = longint'(signed'(nrn_potential[n]));
            th = longint'(signed'(nrn_threshold[n]));
            vn = ((longint'(leak) * v) >>> LEAK_SHIFT)
                 + (longint'(signed'(nrn_current[n])) >>> CURRENT_SHIFT);
            if (vn > 32767) vn = 32767;
            if (vn < -32768) vn = -32768;
            r.fired = (vn >= th);
            if (r.fired) vn = vn - th;
            nrn_potential[n] = 16'(vn);
            nrn_spiked[n] = r.fired;
            nrn_current[n] = '0;
            r.new_potential = 16'(vn);
            r.skipped = 1'b0;
        end
        update_results_q.push_back(r);
    endtask

    task automatic apply_item(input t_item it);
        case (it.opcode)
            OP_ROW_PTR: if (it.source_index <= SRC_N) row_ptr[it.source_index] = it.synapse_pos;
            OP_SYNAPSE: if (it.synapse_pos < SYN_N) begin
                syn_target[it.synapse_pos] = it.neuron_index;
                syn_weight[it.synapse_pos] = it.weight;
            end
            OP_NEURON: begin
                nrn_potential[it.neuron_index]  = it.potential;
                nrn_threshold[it.neuron_index]  = it.threshold;
                nrn_refractory[it.neuron_index] = it.refractory_in;
                nrn_spiked[it.neuron_index]     = it.spiked_in;
            end
            OP_SPIKE:  walk_row(it.source_index);
            OP_UPDATE: lif_update(it.neuron_index);
            default: ;
        endcase
    endtask

    task automatic check_result(input t_result got);
        t_result want;
        if (update_results_q.size() == 0) begin
            $display("%0t: result with none outstanding: fired %0b potential %0d skipped %0b",
                     $time, got.fired, got.new_potential, got.skipped);
            o_fail_count++;
            return;
        end
        want = update_results_q.pop_front();
        if (got.fired !== want.fired) begin
            $display("%0t: fired expected %0b actual %0b", $time, want.fired, got.fired);
            o_fail_count++;
        end
        if (got.new_potential !== want.new_potential) begin
            $display("%0t: new_potential expected %0d actual %0d",
                     $time, want.new_potential, got.new_potential);
            o_fail_count++;
        end
        if (got.skipped !== want.skipped) begin
            $display("%0t: skipped expected %0b actual %0b", $time, want.skipped, got.skipped);
            o_fail_count++;
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_result_count = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            leak = LEAK_RESET;
            neuron_limit = COUNT_RESET;
            source_limit = COUNT_RESET;
            for (int k = 0; k < NRN_N; k++) nrn_current[k] = '0;
            update_results_q.delete();
        end else begin
            // Results first: a result can never belong to an item accepted at the same edge.
            if (results.valid && results.ready) begin
                o_result_count++;
                check_result(results.data);
            end
            if (items.valid && items.ready) apply_item(items.data);
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_LEAK:    leak = pwdata[15:0];
                    REG_NEURONS: neuron_limit = pwdata[10:0];
                    REG_SOURCES: source_limit = pwdata[10:0];
                    default: ;
                endcase
            end
        end
    end
endmodule

[test/sparse_spiking_neuron_step_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sparse spiking neuron step testbench
// Loads a small synapse network, then drives directed and random loads,
// spikes and updates under several register settings with random idling.
// ----------------------------------------------------------------------------
module sparse_spiking_neuron_step_test;
    import ssn_pkg::*;

    localparam logic [2:0] OP_UNUSED_LO = 3'd5;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;
    localparam int SYN_USED = 128;
    localparam int DRAIN_CYCLES = 1000;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    int          result_count;
    bit          idling;
    int          sent;
    logic [10:0] cur_neurons;

    ssn_item_if   in_ch ();
    ssn_result_if out_ch ();

    sparse_spiking_neuron_step i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_in(in_ch), .m_out(out_ch)
    );

    ssn_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .items(in_ch), .results(out_ch),
        .o_fail_count(fail_count), .o_pending(pending), .o_result_count(result_count)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    initial begin
        #5ms;
        $display("FAIL");
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) out_ch.ready <= 1'b0;
        else out_ch.ready <= !(idling && $urandom_range(99) < 8);
    end

    task automatic send(input t_item it);
        while (idling && $urandom_range(99) < 8) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        sent++;
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        // Spikes give no result, so a long row may still be walking.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_item noise_item(input logic [2:0] op);
        t_item it;
        it = t_item'($bits(t_item)'({$urandom, $urandom, $urandom}));
        it.opcode = op;
        return it;
    endfunction

    function automatic logic [9:0] pick_neuron();
        if ($urandom_range(9) == 0) return 10'd1023;
        return 10'($urandom_range(31));
    endfunction

    function automatic logic [10:0] pick_source();
        int r;
        r = $urandom_range(19);
        if (r == 16) return 11'd1023;
        if (r == 17) return 11'd20;
        if (r >= 18) return 11'($urandom_range(1024, 2047));
        return 11'(r);
    endfunction

    function automatic t_item neuron_item(input logic [9:0] n);
        t_item it;
        it = noise_item(OP_NEURON);
        it.neuron_index  = n;
        it.refractory_in = ($urandom_range(5) == 0);
        return it;
    endfunction

    function automatic t_item row_item(input logic [10:0] slot, input logic [14:0] pos);
        t_item it;
        it = noise_item(OP_ROW_PTR);
        it.source_index = slot;
        it.synapse_pos  = pos;
        return it;
    endfunction

    function automatic t_item op_item(input logic [2:0] op, input logic [10:0] src,
                                      input logic [9:0] n);
        t_item it;
        it = noise_item(op);
        it.source_index = src;
        it.neuron_index = n;
        return it;
    endfunction

    task automatic random_items(input int count);
        t_item it;
        int r;
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(99);
            if (r < 10) begin
                if ($urandom_range(3) == 0)
                    it = row_item(11'($urandom_range(1025, 2047)), 15'($urandom));
                else if ($urandom_range(5) == 0)
                    it = row_item($urandom_range(1) ? 11'd1023 : 11'd1024,
                                  15'($urandom_range(SYN_USED)));
                else
                    it = row_item(11'($urandom_range(16)), 15'($urandom_range(SYN_USED)));
            end else if (r < 20) begin
                it = noise_item(OP_SYNAPSE);
                it.synapse_pos = ($urandom_range(4) == 0) ? 15'($urandom_range(16384, 32767))
                                                          : 15'($urandom_range(SYN_USED - 1));
            end else if (r < 28) begin
                it = neuron_item(pick_neuron());
            end else if (r < 60) begin
                it = op_item(OP_SPIKE, pick_source(), 10'($urandom));
            end else if (r < 96) begin
                if (cur_neurons < 1024 && $urandom_range(6) == 0)
                    it = op_item(OP_UPDATE, 11'($urandom),
                                 10'($urandom_range(int'(cur_neurons), 1023)));
                else
                    it = op_item(OP_UPDATE, 11'($urandom), pick_neuron());
            end else begin
                it = noise_item(3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)));
            end
            send(it);
            if (k == count / 2 && $urandom_range(1)) drain();
        end
    endtask

    task automatic configure(input logic [15:0] lf, input logic [10:0] nc, input logic [10:0] sc);
        reg_write(REG_LEAK, 32'(lf));
        reg_write(REG_NEURONS, 32'(nc));
        reg_write(REG_SOURCES, 32'(sc));
        cur_neurons = nc;
    endtask

    initial begin
        t_item it;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        idling = 1'b1;
        sent = 0;
        cur_neurons = COUNT_RESET;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Small network: 33 neurons, 128 synapses, rows for sources 0..15 and 1023.
        for (int k = 0; k < 32; k++) send(neuron_item(10'(k)));
        send(neuron_item(10'd1023));
        for (int k = 0; k < SYN_USED; k++) begin
            it = noise_item(OP_SYNAPSE);
            it.synapse_pos = 15'(k);
            it.neuron_index = ($urandom_range(3) == 0) ? 10'd1023 : 10'($urandom_range(31));
            send(it);
        end
        for (int k = 0; k <= 16; k++) send(row_item(11'(k), 15'(k * 8)));
        send(row_item(11'd1023, 15'd100));
        send(row_item(11'd1024, 15'(SYN_USED)));

        // Directed: reversed row at the pointer extremes, ignored loads and spikes.
        send(row_item(11'd20, 15'h7fff));
        send(row_item(11'd21, 15'd16384));
        send(row_item(11'd2047, 15'h7fff));
        it = noise_item(OP_SYNAPSE);
        it.synapse_pos = 15'h7fff;
        send(it);
        send(op_item(OP_SPIKE, 11'd20, 10'd0));
        send(op_item(OP_SPIKE, 11'd1024, 10'd0));
        send(op_item(OP_SPIKE, 11'd2047, 10'd0));
        // Refractory neuron, and a neuron that fires with the lowest threshold.
        it = noise_item(OP_NEURON);
        it.neuron_index = 10'd1;
        it.potential = 16'sh8000;
        it.refractory_in = 1'b1;
        send(it);
        send(op_item(OP_UPDATE, 11'd0, 10'd1));
        it = noise_item(OP_NEURON);
        it.neuron_index = 10'd2;
        it.potential = 16'sh7fff;
        it.threshold = 16'sh8000;
        it.refractory_in = 1'b0;
        send(it);
        send(op_item(OP_UPDATE, 11'd0, 10'd2));
        it = noise_item(OP_NEURON);
        it.neuron_index = 10'd3;
        it.potential = 16'sh7fff;
        it.threshold = 16'sh7fff;
        it.refractory_in = 1'b0;
        send(it);
        for (int k = 0; k < 6; k++) send(op_item(OP_SPIKE, 11'(k), 10'd0));
        send(op_item(OP_SPIKE, 11'd1023, 10'd0));
        send(op_item(OP_UPDATE, 11'd0, 10'd3));
        send(op_item(OP_UPDATE, 11'd0, 10'd1023));
        for (logic [2:0] op = OP_UNUSED_LO; op != 3'd0; op++) send(noise_item(op));

        random_items(60);
        drain();
        configure(16'd0, 11'd1, 11'd1);
        random_items(40);
        drain();
        configure(16'hffff, 11'd1024, 11'd1024);
        idling = 1'b0;
        random_items(60);
        idling = 1'b1;
        drain();
        configure(16'd16384, 11'd20, 11'd18);
        random_items(50);
        drain();
        configure(16'd14746, 11'd1000, 11'd1023);
        random_items(60);
        drain();

        $display("Run sent %0d items under five register settings and checked %0d results.",
                 sent, result_count);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
